### rtl/pbqc_pkg.sv
package pbqc_pkg;

    // Default ceiling of the quality level
    localparam int unsigned PBQC_TOP_LEVEL = 5;

    // Reset values of the controller state
    localparam logic [7:0]  RESET_FPS        = 8'd25;
    localparam logic [7:0]  RESET_LEVEL      = 8'd3;
    localparam logic [31:0] RESET_LAST_FRAME = 32'd1000000;

    // Limits of the tick counters
    localparam logic [7:0]  REBUFFER_LIMIT = 8'd3;
    localparam logic [1:0]  STALL_LIMIT    = 2'd3;

    // Command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_PACKET = 1'b1;

    // Level change flags
    localparam logic [1:0] CHG_NONE    = 2'd0;
    localparam logic [1:0] CHG_LOWERED = 2'd1;
    localparam logic [1:0] CHG_RAISED  = 2'd2;

    typedef enum logic [2:0] {
        ST_PACKET    = 3'd0,
        ST_STALLED   = 3'd1,
        ST_REBUFFER  = 3'd2,
        ST_PLAYED    = 3'd3,
        ST_ENDED     = 3'd4
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic [31:0] frame_number;
        logic [15:0] packet_bytes;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] buffer_frames;
        logic [7:0]  quality_level;
        logic [1:0]  level_change;
        logic        new_frame_started;
        logic [31:0] finished_frame_bytes;
    } t_result;

endpackage

### rtl/playout_buffer_quality_controller_top.sv
// Playout buffer quality controller. Each beat is a packet arrival or a one-second
// playout tick; every beat yields exactly one result beat. The block takes one beat
// per clock cycle while results are taken. A beat passes one input register, then
// the state update (frame compare, saturating adds, five-second threshold compare)
// that writes the result register. Ready upstream drops only while both registers
// hold beats and the result is stalled. The user must write frames_per_second via
// i_cfg_we / i_cfg_data while no beat is in flight; the block does not enforce it.
module playout_buffer_quality_controller_top
    import pbqc_pkg::*;
#(
    parameter int unsigned TOP_LEVEL = PBQC_TOP_LEVEL
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_frame_number,
    input  logic [15:0] i_packet_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_buffer_frames,
    output logic [7:0]  o_quality_level,
    output logic [1:0]  o_level_change,
    output logic        o_new_frame_started,
    output logic [31:0] o_finished_frame_bytes
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    proceed;
    t_result result;

    assign proceed    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proceed;

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.cmd          <= i_cmd;
            r_in.frame_number <= i_frame_number;
            r_in.packet_bytes <= i_packet_bytes;
        end
    end

    pbqc_core #(
        .TOP_LEVEL (TOP_LEVEL)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (proceed),
        .i_item     (r_in),
        .o_result   (result)
    );

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed) begin
            r_out <= result;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_status               = r_out.status;
    assign o_buffer_frames        = r_out.buffer_frames;
    assign o_quality_level        = r_out.quality_level;
    assign o_level_change         = r_out.level_change;
    assign o_new_frame_started    = r_out.new_frame_started;
    assign o_finished_frame_bytes = r_out.finished_frame_bytes;

endmodule

### rtl/pbqc_core.sv
module pbqc_core
    import pbqc_pkg::*;
#(
    parameter int unsigned TOP_LEVEL = PBQC_TOP_LEVEL
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_fire,
    input  t_item      i_item,
    output t_result    o_result
);

    logic [7:0]  r_fps;
    logic [31:0] r_buf;
    logic [31:0] r_buf_last_tick;
    logic [1:0]  r_stall;
    logic [7:0]  r_rebuf;
    logic [7:0]  r_level;
    logic [31:0] r_last_frame;
    logic [31:0] r_bytes;
    logic        r_ended;

    logic [31:0] n_buf;
    logic [31:0] n_buf_last_tick;
    logic [1:0]  n_stall;
    logic [7:0]  n_rebuf;
    logic [7:0]  n_level;
    logic [31:0] n_last_frame;
    logic [31:0] n_bytes;
    logic        n_ended;

    logic [31:0] fps_wide;
    logic [10:0] five_sec;
    logic [32:0] byte_sum;
    logic [7:0]  top_level;

    assign fps_wide  = {24'd0, r_fps};
    // Five seconds of frames: 4*fps + fps
    assign five_sec  = {1'b0, r_fps, 2'b00} + {3'd0, r_fps};
    assign byte_sum  = {1'b0, r_bytes} + {17'd0, i_item.packet_bytes};
    assign top_level = 8'(TOP_LEVEL);

    // Compute the next state and the result of the current beat
    always_comb begin
        n_buf           = r_buf;
        n_buf_last_tick = r_buf_last_tick;
        n_stall         = r_stall;
        n_rebuf         = r_rebuf;
        n_level         = r_level;
        n_last_frame    = r_last_frame;
        n_bytes         = r_bytes;
        n_ended         = r_ended;
        o_result        = '0;

        if (i_item.cmd == CMD_PACKET) begin
            o_result.status = ST_PACKET;
            if (i_item.frame_number == r_last_frame) begin
                // Same frame: accumulate bytes, saturating
                n_bytes = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
            end else begin
                o_result.new_frame_started    = 1'b1;
                o_result.finished_frame_bytes = r_bytes;
                n_buf        = (r_buf == 32'hFFFF_FFFF) ? r_buf : r_buf + 32'd1;
                n_last_frame = i_item.frame_number;
                n_bytes      = {16'd0, i_item.packet_bytes};
            end
            // Drop a level after repeated rebuffers
            if (r_rebuf >= REBUFFER_LIMIT && r_level > 8'd1) begin
                n_level = r_level - 8'd1;
                n_rebuf = '0;
                o_result.level_change = o_result.level_change | CHG_LOWERED;
            end
            // Raise a level and trim the buffer when it runs deep
            if (n_buf > {21'd0, five_sec} && n_level < top_level) begin
                n_level = n_level + 8'd1;
                n_buf   = fps_wide;
                o_result.level_change = o_result.level_change | CHG_RAISED;
            end
        end else if (r_ended) begin
            o_result.status = ST_ENDED;
        end else if (r_buf < fps_wide) begin
            if (r_buf_last_tick == r_buf) begin
                // Buffer did not move: stall
                if (r_stall < STALL_LIMIT) begin
                    n_stall = r_stall + 2'd1;
                end
                if (n_stall >= STALL_LIMIT) begin
                    n_ended = 1'b1;
                end
                o_result.status = ST_STALLED;
            end else begin
                n_stall = '0;
                if (r_rebuf != 8'hFF) begin
                    n_rebuf = r_rebuf + 8'd1;
                end
                o_result.status = ST_REBUFFER;
            end
            n_buf_last_tick = r_buf;
        end else begin
            // Play one second of frames
            n_stall         = '0;
            n_rebuf         = '0;
            n_buf           = r_buf - fps_wide;
            n_buf_last_tick = r_buf - fps_wide;
            o_result.status = ST_PLAYED;
        end

        o_result.buffer_frames = n_buf;
        o_result.quality_level = n_level;
    end

    // Hold the frame rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps <= RESET_FPS;
        end else if (i_cfg_we) begin
            r_fps <= i_cfg_data;
        end
    end

    // Advance the controller state on each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf           <= '0;
            r_buf_last_tick <= '0;
            r_stall         <= '0;
            r_rebuf         <= '0;
            r_level         <= RESET_LEVEL;
            r_last_frame    <= RESET_LAST_FRAME;
            r_bytes         <= '0;
            r_ended         <= 1'b0;
        end else if (i_fire) begin
            r_buf           <= n_buf;
            r_buf_last_tick <= n_buf_last_tick;
            r_stall         <= n_stall;
            r_rebuf         <= n_rebuf;
            r_level         <= n_level;
            r_last_frame    <= n_last_frame;
            r_bytes         <= n_bytes;
            r_ended         <= n_ended;
        end
    end

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level >= 8'd1 && r_level <= top_level)
        else $error("quality level out of range");

    a_stall_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stall == STALL_LIMIT |-> r_ended)
        else $error("stall limit reached without ending the stream");

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |=> r_ended)
        else $error("stream end cleared");

    a_tick_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.cmd == CMD_TICK |-> o_result.level_change == CHG_NONE &&
            !o_result.new_frame_started)
        else $error("tick result reports a packet event");
`endif

endmodule

### dv/tb_playout_buffer_quality_controller_top.sv
module tb_playout_buffer_quality_controller_top;
    import pbqc_pkg::*;

    localparam logic [31:0] HIGH_SECONDS = 32'd5;
    localparam int          MAX_GAP      = 12;
    localparam int          LONG_HOLD    = 400;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          PHASE_BEATS  = 130;
    localparam int          CYCLE_LIMIT  = 500000;

    // One row of the directed plan: a register write or an input beat
    typedef struct {
        bit          is_cfg;
        logic [7:0]  fps;
        logic        cmd;
        logic [31:0] frame;
        logic [15:0] bytes;
        bit          typed;
        t_result     result;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_cmd;
    logic [31:0] i_frame_number;
    logic [15:0] i_packet_bytes;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [31:0] o_buffer_frames;
    logic [7:0]  o_quality_level;
    logic [1:0]  o_level_change;
    logic        o_new_frame_started;
    logic [31:0] o_finished_frame_bytes;

    // Controller state as predicted from the accepted beats
    logic [7:0]  m_fps          = RESET_FPS;
    logic [31:0] m_buf          = '0;
    logic [31:0] m_buf_at_tick  = '0;
    logic [1:0]  m_stall        = '0;
    logic [7:0]  m_rebuf        = '0;
    logic [7:0]  m_level        = RESET_LEVEL;
    logic [31:0] m_last_frame   = RESET_LAST_FRAME;
    logic [31:0] m_byte_total   = '0;
    bit          m_ended        = 1'b0;

    t_result     expected_results[$];
    t_plan_row   directed_plan[$];
    bit          beat_typed = 1'b0;
    t_result     beat_exp;
    bit          idle_on  = 1'b1;
    bit          hold_req = 1'b0;
    int          failures = 0;
    int          cycle_count = 0;

    playout_buffer_quality_controller_top DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_cmd                  (i_cmd),
        .i_frame_number         (i_frame_number),
        .i_packet_bytes         (i_packet_bytes),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_status               (o_status),
        .o_buffer_frames        (o_buffer_frames),
        .o_quality_level        (o_quality_level),
        .o_level_change         (o_level_change),
        .o_new_frame_started    (o_new_frame_started),
        .o_finished_frame_bytes (o_finished_frame_bytes)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one beat to the predicted state and return the result it causes
    function automatic t_result advance_playout(input logic c, input logic [31:0] f,
                                                input logic [15:0] b);
        t_result     r;
        logic [32:0] sum;
        r = '0;
        r.status = ST_PACKET;
        if (c == CMD_PACKET) begin
            if (f == m_last_frame) begin
                sum = {1'b0, m_byte_total} + {17'd0, b};
                m_byte_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end else begin
                r.new_frame_started    = 1'b1;
                r.finished_frame_bytes = m_byte_total;
                if (m_buf != 32'hFFFF_FFFF)
                    m_buf = m_buf + 32'd1;
                m_last_frame = f;
                m_byte_total = {16'd0, b};
            end
            // Lower on repeated rebuffering, unless already at the floor
            if (m_rebuf >= REBUFFER_LIMIT && m_level > 8'd1) begin
                m_level = m_level - 8'd1;
                m_rebuf = '0;
                r.level_change = r.level_change | CHG_LOWERED;
            end
            // Raise and trim on a deep buffer, unless already at the ceiling
            if (m_buf > {24'd0, m_fps} * HIGH_SECONDS && m_level < PBQC_TOP_LEVEL) begin
                m_level = m_level + 8'd1;
                m_buf   = {24'd0, m_fps};
                r.level_change = r.level_change | CHG_RAISED;
            end
        end else if (m_ended) begin
            r.status = ST_ENDED;
        end else if (m_buf < {24'd0, m_fps}) begin
            if (m_buf_at_tick == m_buf) begin
                if (m_stall < STALL_LIMIT)
                    m_stall = m_stall + 2'd1;
                if (m_stall >= STALL_LIMIT)
                    m_ended = 1'b1;
                r.status = ST_STALLED;
            end else begin
                m_stall = '0;
                if (m_rebuf != 8'hFF)
                    m_rebuf = m_rebuf + 8'd1;
                r.status = ST_REBUFFER;
            end
            m_buf_at_tick = m_buf;
        end else begin
            m_stall = '0;
            m_rebuf = '0;
            m_buf   = m_buf - {24'd0, m_fps};
            m_buf_at_tick = m_buf;
            r.status = ST_PLAYED;
        end
        r.buffer_frames = m_buf;
        r.quality_level = m_level;
        return r;
    endfunction

    task automatic plan_beat(input logic c, input logic [31:0] f, input logic [15:0] b);
        t_plan_row row;
        row = '{default: '0};
        row.cmd   = c;
        row.frame = f;
        row.bytes = b;
        directed_plan.push_back(row);
    endtask

    task automatic plan_checked(input logic c, input logic [31:0] f, input logic [15:0] b,
                                input t_status st, input logic [31:0] bufv,
                                input logic [7:0] lvl, input logic [1:0] chg,
                                input logic nf, input logic [31:0] fin);
        t_plan_row row;
        row = '{default: '0};
        row.cmd   = c;
        row.frame = f;
        row.bytes = b;
        row.typed = 1'b1;
        row.result.status               = st;
        row.result.buffer_frames        = bufv;
        row.result.quality_level        = lvl;
        row.result.level_change         = chg;
        row.result.new_frame_started    = nf;
        row.result.finished_frame_bytes = fin;
        directed_plan.push_back(row);
    endtask

    task automatic plan_cfg(input logic [7:0] v);
        t_plan_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.fps    = v;
        directed_plan.push_back(row);
    endtask

    // Offer one beat, with a random lead gap; entered and left at a falling edge
    task automatic send_beat(input logic c, input logic [31:0] f, input logic [15:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= c;
        i_frame_number <= f;
        i_packet_bytes <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    // Hold the input idle until every expected result beat is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_fps(input logic [7:0] v);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        m_fps = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random beat; unless allow_end, a tick that would stall a third time is a new frame
    task automatic send_random_beat(input int pkt_pct, input bit allow_end);
        logic        c;
        logic [31:0] f;
        logic [15:0] b;
        bit          forced;
        c = ($urandom_range(1, 100) <= pkt_pct) ? CMD_PACKET : CMD_TICK;
        forced = !allow_end && c == CMD_TICK && !m_ended && m_buf < {24'd0, m_fps}
                 && m_buf_at_tick == m_buf && m_stall == STALL_LIMIT - 2'd1;
        f = $urandom();
        b = 16'($urandom());
        if (forced) begin
            c = CMD_PACKET;
            f = m_last_frame + 32'd1;
        end else if (c == CMD_PACKET) begin
            case ($urandom_range(0, 9))
                0, 1, 2: f = m_last_frame;
                3:       f = m_last_frame + 32'd1;
                default: ;
            endcase
        end
        case ($urandom_range(0, 7))
            0:       b = 16'h0000;
            1:       b = 16'hFFFF;
            default: ;
        endcase
        beat_typed = 1'b0;
        send_beat(c, f, b);
    endtask

    // Predict on every input beat, then check every result beat against the oldest
    always @(posedge i_clk) begin : scoreboard
        t_result pred;
        t_result exp_r;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pred = advance_playout(i_cmd, i_frame_number, i_packet_bytes);
                expected_results.push_back(beat_typed ? beat_exp : pred);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expected result");
                    failures++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, o_status);
                        failures++;
                    end
                    if (o_buffer_frames !== exp_r.buffer_frames) begin
                        $error("buffer_frames: expected %0d, got %0d",
                               exp_r.buffer_frames, o_buffer_frames);
                        failures++;
                    end
                    if (o_quality_level !== exp_r.quality_level) begin
                        $error("quality_level: expected %0d, got %0d",
                               exp_r.quality_level, o_quality_level);
                        failures++;
                    end
                    if (o_level_change !== exp_r.level_change) begin
                        $error("level_change: expected %0d, got %0d",
                               exp_r.level_change, o_level_change);
                        failures++;
                    end
                    if (o_new_frame_started !== exp_r.new_frame_started) begin
                        $error("new_frame_started: expected %0d, got %0d",
                               exp_r.new_frame_started, o_new_frame_started);
                        failures++;
                    end
                    if (o_finished_frame_bytes !== exp_r.finished_frame_bytes) begin
                        $error("finished_frame_bytes: expected %0d, got %0d",
                               exp_r.finished_frame_bytes, o_finished_frame_bytes);
                        failures++;
                    end
                end
            end
        end
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls per beat, one long hold-off on request
    initial begin : receiver
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_req) begin
                gap = LONG_HOLD;
                hold_req = 1'b0;
            end
            repeat (gap) begin
                i_out_ready <= 1'b0;
                @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [7:0] phase_fps [10];
        int         pkt_pct;
        int         guard;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_cmd          = CMD_TICK;
        i_frame_number = '0;
        i_packet_bytes = '0;
        phase_fps = '{8'd3, 8'd255, 8'd1, 8'd0, 8'd5, 8'd6, 8'd12, 8'd4, 8'd2, 8'd7};

        // After reset: stall on an empty buffer, same frame as the reset one, extremes
        plan_checked(CMD_TICK, 32'd0, 16'd0, ST_STALLED, 32'd0, RESET_LEVEL, CHG_NONE,
                     1'b0, 32'd0);
        plan_checked(CMD_PACKET, RESET_LAST_FRAME, 16'hFFFF, ST_PACKET, 32'd0, RESET_LEVEL,
                     CHG_NONE, 1'b0, 32'd0);
        plan_checked(CMD_PACKET, 32'd0, 16'd0, ST_PACKET, 32'd1, RESET_LEVEL, CHG_NONE,
                     1'b1, 32'h0000_FFFF);
        plan_checked(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF, ST_PACKET, 32'd2, RESET_LEVEL,
                     CHG_NONE, 1'b1, 32'd0);
        plan_checked(CMD_PACKET, 32'hFFFF_FFFF, 16'd1, ST_PACKET, 32'd2, RESET_LEVEL,
                     CHG_NONE, 1'b0, 32'd0);
        plan_checked(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, ST_REBUFFER, 32'd2, RESET_LEVEL,
                     CHG_NONE, 1'b0, 32'd0);
        // Three rebuffers, then a packet lowers the level
        plan_beat(CMD_PACKET, 32'd10, 16'd100);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_beat(CMD_PACKET, 32'd11, 16'd200);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_beat(CMD_PACKET, 32'd12, 16'd300);
        // One frame per second: raise and trim, play, two stalls, play
        plan_cfg(8'd1);
        plan_beat(CMD_PACKET, 32'd13, 16'd400);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_beat(CMD_PACKET, 32'd14, 16'd500);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        // Zero frame rate: any buffer above zero is deep, ticks always play; then the ceiling
        plan_cfg(8'd0);
        plan_beat(CMD_PACKET, 32'd15, 16'd1);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_beat(CMD_PACKET, 32'd16, 16'd2);
        plan_beat(CMD_PACKET, 32'd17, 16'd3);
        // Collect rebuffers at a high rate, then drop the rate: lowered then raised
        plan_cfg(8'd20);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_beat(CMD_PACKET, 32'd18, 16'd4);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_beat(CMD_PACKET, 32'd19, 16'd5);
        plan_beat(CMD_TICK, 32'd0, 16'd0);
        plan_cfg(8'd0);
        plan_beat(CMD_PACKET, 32'd20, 16'd6);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part
        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                write_fps(directed_plan[i].fps);
            end else begin
                beat_typed = directed_plan[i].typed;
                beat_exp   = directed_plan[i].result;
                send_beat(directed_plan[i].cmd, directed_plan[i].frame,
                          directed_plan[i].bytes);
            end
        end
        beat_typed = 1'b0;

        // Random phases, one frame rate each
        phase_fps[4] = 8'($urandom_range(1, 16));
        phase_fps[6] = 8'($urandom_range(1, 255));
        for (int p = 0; p < 10; p++) begin
            write_fps(phase_fps[p]);
            idle_on = ($urandom_range(0, 3) != 0);
            pkt_pct = (phase_fps[p] >= 8'd100) ? 55 : $urandom_range(45, 90);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 1 && n == 20)
                    hold_req = 1'b1;
                if (p == 4 && n == 60)
                    drain_results();
                send_random_beat(pkt_pct, 1'b0);
            end
        end

        // Drain the buffer at the top rate until three stalls end the stream
        write_fps(8'd255);
        idle_on = 1'b1;
        guard = 0;
        while (!m_ended && guard < 60) begin
            beat_typed = 1'b0;
            send_beat(CMD_TICK, $urandom(), 16'($urandom()));
            guard++;
        end
        // Beats after the end of the stream
        repeat (10) send_random_beat(50, 1'b1);

        drain_results();
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
